/* sv/pedest_pkg.sv */
// Shared widths, constants and control/result types of the phase energy peak delay estimator.
`timescale 1ns / 1ps
`default_nettype none

package pedest_pkg;

   localparam int BIN_W            = 24;
   localparam int MAG_W            = BIN_W;
   localparam int SQ_W             = 2 * MAG_W;
   localparam int PHASE_W          = 6;
   localparam int ENERGY_W         = 57;
   localparam int TOTAL_W          = 63;
   localparam int RATIO_W          = 23;
   localparam int DELAY_W          = 16;
   localparam int ADV_W            = 11;
   localparam int Q16_FRAC         = 16;

   localparam int DEF_MAX_PHASES   = 64;
   localparam int DEF_FRAME_LENGTH = 512;

   localparam logic [ADV_W-1:0]   ADV_RESET = 11'd240;
   localparam logic [RATIO_W-1:0] Q16_ONE   = 23'd65536;

   typedef struct packed {
      logic capture;
      logic mul;
      logic acc;
      logic close;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_bin;
      logic last_phase;
      logic phase_ok;
      logic total_zero;
      logic div_done;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_number;
      logic [ENERGY_W-1:0] phase_energy;
      logic                frame_done;
      logic [TOTAL_W-1:0]  total_energy;
      logic [ENERGY_W-1:0] peak_energy;
      logic [PHASE_W-1:0]  peak_phase;
      logic [RATIO_W-1:0]  peak_to_average;
      logic [DELAY_W-1:0]  delay_samples;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/pedest_req_if.sv */
// Bin transaction channel: valid, ready and one complex bin with its phase markers.
`timescale 1ns / 1ps
`default_nettype none

interface pedest_req_if import pedest_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic signed [BIN_W-1:0] bin_real;
   logic signed [BIN_W-1:0] bin_imag;
   logic                    last_bin;
   logic                    last_phase;

   modport source (output valid, output bin_real, output bin_imag, output last_bin,
                   output last_phase, input ready);
   modport sink   (input valid, input bin_real, input bin_imag, input last_bin,
                   input last_phase, output ready);

endinterface

`default_nettype wire

/* sv/pedest_rsp_if.sv */
// Result transaction channel: valid, ready and the phase energy with the frame summary.
`timescale 1ns / 1ps
`default_nettype none

interface pedest_rsp_if import pedest_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [PHASE_W-1:0]  phase_number;
   logic [ENERGY_W-1:0] phase_energy;
   logic                frame_done;
   logic [TOTAL_W-1:0]  total_energy;
   logic [ENERGY_W-1:0] peak_energy;
   logic [PHASE_W-1:0]  peak_phase;
   logic [RATIO_W-1:0]  peak_to_average;
   logic [DELAY_W-1:0]  delay_samples;

   modport source (output valid, output phase_number, output phase_energy,
                   output frame_done, output total_energy, output peak_energy,
                   output peak_phase, output peak_to_average, output delay_samples,
                   input ready);
   modport sink   (input valid, input phase_number, input phase_energy,
                   input frame_done, input total_energy, input peak_energy,
                   input peak_phase, input peak_to_average, input delay_samples,
                   output ready);

endinterface

`default_nettype wire

/* sv/phase_energy_peak_delay_estimator_core.sv */
// Each bin transaction is captured, both parts squared, then accumulated before the next.
// A bin that closes a phase within the limit adds a close step and a load step before its
// result is valid; a frame-closing bin also spends a prep step that forms the dividend and,
// unless the total is zero, a restoring division of one quotient bit per cycle.
// A result that is not taken holds the block in its load step until rsp ready rises.
// Reset (synchronous, active high) clears all frame state and sets frame_advance to 240.
`timescale 1ns / 1ps
`default_nettype none

module phase_energy_peak_delay_estimator_core import pedest_pkg::*; #(
   parameter int MAX_PHASES   = DEF_MAX_PHASES,
   parameter int FRAME_LENGTH = DEF_FRAME_LENGTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [ADV_W-1:0] csr_wr_data,
   pedest_req_if.sink            req_chan,
   pedest_rsp_if.source          rsp_chan
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_data;
   logic       rsp_valid;
   logic       req_ready;

   pedest_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pedest_dp #(
      .MAX_PHASES   (MAX_PHASES),
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .bin_real    (req_chan.bin_real),
      .bin_imag    (req_chan.bin_imag),
      .last_bin    (req_chan.last_bin),
      .last_phase  (req_chan.last_phase),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.phase_number    = rsp_data.phase_number;
   assign rsp_chan.phase_energy    = rsp_data.phase_energy;
   assign rsp_chan.frame_done      = rsp_data.frame_done;
   assign rsp_chan.total_energy    = rsp_data.total_energy;
   assign rsp_chan.peak_energy     = rsp_data.peak_energy;
   assign rsp_chan.peak_phase      = rsp_data.peak_phase;
   assign rsp_chan.peak_to_average = rsp_data.peak_to_average;
   assign rsp_chan.delay_samples   = rsp_data.delay_samples;

endmodule

`default_nettype wire

/* sv/pedest_ctrl.sv */
// Controller state machine that sequences capture, squaring, accumulation, division and output.
`timescale 1ns / 1ps
`default_nettype none

module pedest_ctrl import pedest_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_CLOSE = 3'd3;
   localparam logic [2:0] ST_PREP  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last_bin ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            // A phase past the limit gives a result only when it also closes the frame.
            priority if (status.last_phase) begin
               state_in = ST_PREP;
            end else if (status.phase_ok) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.total_zero ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/pedest_dp.sv */
// Datapath: squaring, phase accumulation, peak tracking, restoring divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module pedest_dp import pedest_pkg::*; #(
   parameter int MAX_PHASES   = DEF_MAX_PHASES,
   parameter int FRAME_LENGTH = DEF_FRAME_LENGTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [ADV_W-1:0]        csr_wr_data,
   input  wire logic signed [BIN_W-1:0] bin_real,
   input  wire logic signed [BIN_W-1:0] bin_imag,
   input  wire logic                    last_bin,
   input  wire logic                    last_phase,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data
);

   localparam int BIN_LIMIT = FRAME_LENGTH / 2 + 1;
   localparam int BC_W      = $clog2(BIN_LIMIT + 1);
   localparam int PC_W      = $clog2(MAX_PHASES + 1);
   localparam int NUM_W     = ENERGY_W + PC_W;
   localparam int DVD_W     = NUM_W + Q16_FRAC;
   localparam int DC_W      = $clog2(DVD_W);
   localparam int REM_W     = TOTAL_W + 1;
   localparam int PROD_W    = ADV_W + PHASE_W;

   // Frame state and configuration.
   logic [ADV_W-1:0]    adv_ff, adv_in;
   logic [ENERGY_W-1:0] acc_ff, acc_in;
   logic [BC_W-1:0]     bin_cnt_ff, bin_cnt_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [ENERGY_W-1:0] best_ff, best_in;
   logic [PHASE_W-1:0]  best_phase_ff, best_phase_in;
   logic [PC_W-1:0]     phase_cnt_ff, phase_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [MAG_W-1:0]    mag_re_ff, mag_re_in;
   logic [MAG_W-1:0]    mag_im_ff, mag_im_in;
   logic                last_bin_ff, last_bin_in;
   logic                last_phase_ff, last_phase_in;
   logic [SQ_W-1:0]     sq_re_ff, sq_re_in;
   logic [SQ_W-1:0]     sq_im_ff, sq_im_in;
   logic [PHASE_W-1:0]  pn_ff, pn_in;
   logic [ENERGY_W-1:0] pe_ff, pe_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [RATIO_W-1:0]  quot_ff, quot_in;
   logic [DC_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                phase_ok;
   logic                bin_ok;
   logic [NUM_W-1:0]    num;
   logic [PROD_W-1:0]   delay_prod;
   logic [REM_W-1:0]    rem_shift;
   logic [REM_W-1:0]    rem_sub;
   logic                rem_ge;

   function automatic logic [MAG_W-1:0] magnitude(input logic [BIN_W-1:0] raw);
      logic [MAG_W-1:0] r;
      r = raw;
      return r[MAG_W-1] ? (~r + 1'b1) : r;
   endfunction

   assign phase_ok   = (phase_cnt_ff < PC_W'(MAX_PHASES));
   assign bin_ok     = (bin_cnt_ff < BC_W'(BIN_LIMIT));
   assign num        = NUM_W'(best_ff) * NUM_W'(phase_cnt_ff);
   assign delay_prod = PROD_W'(adv_ff) * PROD_W'(best_phase_ff);
   assign rem_shift  = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
   assign rem_sub    = rem_shift - {1'b0, total_ff};
   assign rem_ge     = (rem_shift >= {1'b0, total_ff});

   always_comb begin
      status.last_bin   = last_bin_ff;
      status.last_phase = last_phase_ff;
      status.phase_ok   = phase_ok;
      status.total_zero = (total_ff == '0);
      status.div_done   = (div_cnt_ff == DC_W'(DVD_W - 1));
      status.out_busy   = rsp_valid_ff & ~rsp_ready;
   end

   always_comb begin
      adv_in        = csr_wr_en ? csr_wr_data : adv_ff;
      acc_in        = acc_ff;
      bin_cnt_in    = bin_cnt_ff;
      total_in      = total_ff;
      best_in       = best_ff;
      best_phase_in = best_phase_ff;
      phase_cnt_in  = phase_cnt_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      mag_re_in     = mag_re_ff;
      mag_im_in     = mag_im_ff;
      last_bin_in   = last_bin_ff;
      last_phase_in = last_phase_ff;
      sq_re_in      = sq_re_ff;
      sq_im_in      = sq_im_ff;
      pn_in         = pn_ff;
      pe_in         = pe_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      delay_in      = delay_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         mag_re_in     = magnitude(bin_real);
         mag_im_in     = magnitude(bin_imag);
         last_bin_in   = last_bin;
         last_phase_in = last_bin & last_phase;
      end

      if (cmd.mul) begin
         sq_re_in = SQ_W'(mag_re_ff) * SQ_W'(mag_re_ff);
         sq_im_in = SQ_W'(mag_im_ff) * SQ_W'(mag_im_ff);
      end

      if (cmd.acc && phase_ok && bin_ok) begin
         acc_in     = acc_ff + ENERGY_W'(sq_re_ff) + ENERGY_W'(sq_im_ff);
         bin_cnt_in = bin_cnt_ff + 1'b1;
      end

      if (cmd.close) begin
         if (phase_ok) begin
            pn_in        = PHASE_W'(phase_cnt_ff);
            pe_in        = acc_ff;
            total_in     = total_ff + TOTAL_W'(acc_ff);
            phase_cnt_in = phase_cnt_ff + 1'b1;
            // Strictly greater keeps the first phase that reached the peak.
            if (acc_ff > best_ff) begin
               best_in       = acc_ff;
               best_phase_in = PHASE_W'(phase_cnt_ff);
            end
         end else begin
            pn_in = '0;
            pe_in = '0;
         end
         acc_in     = '0;
         bin_cnt_in = '0;
      end

      if (cmd.prep) begin
         dvd_in     = {num, {Q16_FRAC{1'b0}}};
         rem_in     = '0;
         div_cnt_in = '0;
         quot_in    = status.total_zero ? Q16_ONE : '0;
         delay_in   = (|delay_prod[PROD_W-1:DELAY_W]) ? '1 : delay_prod[DELAY_W-1:0];
      end

      // One quotient bit per cycle; only the low bits of the quotient are kept.
      if (cmd.div_step) begin
         rem_in     = rem_ge ? rem_sub : rem_shift;
         quot_in    = {quot_ff[RATIO_W-2:0], rem_ge};
         dvd_in     = {dvd_ff[DVD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.load_out) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.phase_number    = pn_ff;
         rsp_data_in.phase_energy    = pe_ff;
         rsp_data_in.frame_done      = last_phase_ff;
         rsp_data_in.total_energy    = last_phase_ff ? total_ff : '0;
         rsp_data_in.peak_energy     = last_phase_ff ? best_ff : '0;
         rsp_data_in.peak_phase      = last_phase_ff ? best_phase_ff : '0;
         rsp_data_in.peak_to_average = last_phase_ff ? quot_ff : '0;
         rsp_data_in.delay_samples   = last_phase_ff ? delay_ff : '0;
         if (last_phase_ff) begin
            total_in      = '0;
            best_in       = '0;
            best_phase_in = '0;
            phase_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_ff        <= ADV_RESET;
         acc_ff        <= '0;
         bin_cnt_ff    <= '0;
         total_ff      <= '0;
         best_ff       <= '0;
         best_phase_ff <= '0;
         phase_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         adv_ff        <= adv_in;
         acc_ff        <= acc_in;
         bin_cnt_ff    <= bin_cnt_in;
         total_ff      <= total_in;
         best_ff       <= best_in;
         best_phase_ff <= best_phase_in;
         phase_cnt_ff  <= phase_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_re_ff     <= mag_re_in;
      mag_im_ff     <= mag_im_in;
      last_bin_ff   <= last_bin_in;
      last_phase_ff <= last_phase_in;
      sq_re_ff      <= sq_re_in;
      sq_im_ff      <= sq_im_in;
      pn_ff         <= pn_in;
      pe_ff         <= pe_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      div_cnt_ff    <= div_cnt_in;
      delay_ff      <= delay_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/pedest_checker.sv */
// Port-level assertions on the result channel and the bind that attaches them to the core.
`timescale 1ns / 1ps
`default_nettype none

module pedest_checker import pedest_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ENERGY_W-1:0] rsp_phase_energy,
   input wire logic                rsp_frame_done,
   input wire logic [TOTAL_W-1:0]  rsp_total_energy,
   input wire logic [ENERGY_W-1:0] rsp_peak_energy,
   input wire logic [PHASE_W-1:0]  rsp_peak_phase,
   input wire logic [RATIO_W-1:0]  rsp_peak_to_average,
   input wire logic [DELAY_W-1:0]  rsp_delay_samples
);

   // A stalled result transaction keeps its valid, phase energy, frame done and total energy.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase_energy)
         && $stable(rsp_frame_done) && $stable(rsp_total_energy))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Outside the frame's last phase the summary fields are all zero.
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_total_energy == '0 && rsp_peak_energy == '0
         && rsp_peak_phase == '0 && rsp_peak_to_average == '0 && rsp_delay_samples == '0)
      else $error("summary fields set without frame done");

   // The peak is never below the average, so the ratio is at least one.
   a_ratio_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_peak_to_average >= Q16_ONE
         && TOTAL_W'(rsp_peak_energy) <= rsp_total_energy)
      else $error("peak-to-average below one or peak above total");

endmodule

bind phase_energy_peak_delay_estimator_core pedest_checker u_pedest_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_phase_energy    (rsp_chan.phase_energy),
   .rsp_frame_done      (rsp_chan.frame_done),
   .rsp_total_energy    (rsp_chan.total_energy),
   .rsp_peak_energy     (rsp_chan.peak_energy),
   .rsp_peak_phase      (rsp_chan.peak_phase),
   .rsp_peak_to_average (rsp_chan.peak_to_average),
   .rsp_delay_samples   (rsp_chan.delay_samples)
);

`default_nettype wire
